/* src/mbsp_pkg.sv */
package mbsp_pkg;

    // Parser phases.
    typedef enum logic [2:0] {
        PH_IGNORE = 3'd0,
        PH_STATUS = 3'd1,
        PH_SYSEX  = 3'd2,
        PH_WAIT2  = 3'd3,
        PH_WAIT1  = 3'd4
    } parse_phase_t;

    // Event kinds on the result channel.
    localparam logic [2:0] EV_MESSAGE     = 3'd0;
    localparam logic [2:0] EV_REALTIME    = 3'd1;
    localparam logic [2:0] EV_SYSEX_START = 3'd2;
    localparam logic [2:0] EV_SYSEX_DATA  = 3'd3;
    localparam logic [2:0] EV_SYSEX_END   = 3'd4;
    localparam logic [2:0] EV_SYSEX_ABORT = 3'd5;

    // Message type reported for song position pointer.
    localparam logic [2:0] MSG_SONG_POS = 3'd7;

    // Held message kinds: channel kinds below TY_MTC_QF.
    localparam logic [3:0] TY_NOTE_OFF  = 4'd0;
    localparam logic [3:0] TY_NOTE_ON   = 4'd1;
    localparam logic [3:0] TY_PROGRAM   = 4'd4;
    localparam logic [3:0] TY_PRESSURE  = 4'd5;
    localparam logic [3:0] TY_MTC_QF    = 4'd7;
    localparam logic [3:0] TY_SONG_POS  = 4'd8;
    localparam logic [3:0] TY_SONG_SEL  = 4'd9;
    localparam logic [3:0] TY_TUNE_REQ  = 4'd10;

    // Status bytes of interest.
    localparam logic [7:0] BYTE_SYSEX_START = 8'hF0;
    localparam logic [7:0] BYTE_MTC_QF      = 8'hF1;
    localparam logic [7:0] BYTE_SONG_POS    = 8'hF2;
    localparam logic [7:0] BYTE_SONG_SEL    = 8'hF3;
    localparam logic [7:0] BYTE_TUNE_REQ    = 8'hF6;
    localparam logic [7:0] BYTE_SYSEX_END   = 8'hF7;
    localparam logic [7:0] BYTE_REALTIME    = 8'hF8;

    // Data byte counts.
    localparam logic [1:0] DC_NONE = 2'd0;
    localparam logic [1:0] DC_ONE  = 2'd1;
    localparam logic [1:0] DC_TWO  = 2'd2;

    // Queue between parser and emitter; depth must be a power of two.
    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = $clog2(Q_DEPTH);
    localparam int Q_CW    = $clog2(Q_DEPTH + 1);

    typedef struct packed {
        logic [2:0] event_kind;
        logic [2:0] message_type;
        logic [7:0] status_value;
        logic [7:0] first_data;
        logic [7:0] second_data;
        logic [1:0] data_count;
    } ev_fields_t;

    // One queue entry: an optional sysex abort ahead of an optional main event.
    typedef struct packed {
        logic       abort;
        logic       main_vld;
        ev_fields_t main;
    } q_entry_t;

    typedef struct packed {
        logic         ok;
        logic [3:0]   kind;
        parse_phase_t nxt;
    } cls_t;

    function automatic cls_t classify(input logic [7:0] st);
        cls_t c;
        c.ok   = 1'b0;
        c.kind = TY_NOTE_OFF;
        c.nxt  = PH_IGNORE;
        if (st[7] && (st < BYTE_SYSEX_START)) begin
            c.ok   = 1'b1;
            c.kind = {1'b0, st[6:4]};
            c.nxt  = ((c.kind == TY_PROGRAM) || (c.kind == TY_PRESSURE)) ? PH_WAIT1 : PH_WAIT2;
        end else begin
            case (st)
                BYTE_MTC_QF: begin
                    c.ok = 1'b1; c.kind = TY_MTC_QF; c.nxt = PH_WAIT1;
                end
                BYTE_SONG_POS: begin
                    c.ok = 1'b1; c.kind = TY_SONG_POS; c.nxt = PH_WAIT2;
                end
                BYTE_SONG_SEL: begin
                    c.ok = 1'b1; c.kind = TY_SONG_SEL; c.nxt = PH_WAIT1;
                end
                BYTE_TUNE_REQ: begin
                    c.ok = 1'b1; c.kind = TY_TUNE_REQ; c.nxt = PH_STATUS;
                end
                default: begin
                    c.ok = 1'b0;
                end
            endcase
        end
        return c;
    endfunction

endpackage

/* src/mbsp_front.sv */
module mbsp_front
    import mbsp_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_rx_byte,
    input  logic       rx_enable,
    input  logic       q_full,
    output logic       push,
    output q_entry_t   entry
);

    parse_phase_t phase_reg, phase_next;
    logic [7:0]   held_status_reg, held_status_next;
    logic [3:0]   held_type_reg, held_type_next;
    logic [7:0]   held_first_reg, held_first_next;
    logic         held_one_reg, held_one_next;

    logic         accept;
    logic         is_status;
    parse_phase_t eff_phase;
    logic [7:0]   cls_status;
    cls_t         cls;
    logic [3:0]   pair_type;

    assign s_ready   = !q_full;
    assign accept    = s_valid && s_ready;
    assign is_status = s_rx_byte[7];
    assign push      = accept && (entry.abort || entry.main_vld);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg       <= PH_IGNORE;
            held_status_reg <= '0;
            held_type_reg   <= '0;
            held_first_reg  <= '0;
            held_one_reg    <= 1'b0;
        end else if (accept) begin
            phase_reg       <= phase_next;
            held_status_reg <= held_status_next;
            held_type_reg   <= held_type_next;
            held_first_reg  <= held_first_next;
            held_one_reg    <= held_one_next;
        end
    end

    always_comb begin
        phase_next       = phase_reg;
        held_status_next = held_status_reg;
        held_type_next   = held_type_reg;
        held_first_next  = held_first_reg;
        held_one_next    = held_one_reg;
        entry            = '0;
        eff_phase        = phase_reg;
        cls_status       = is_status ? s_rx_byte : held_status_reg;
        cls              = classify(cls_status);
        pair_type        = held_type_reg;

        if (s_rx_byte >= BYTE_REALTIME) begin
            entry.main_vld          = 1'b1;
            entry.main.event_kind   = EV_REALTIME;
            entry.main.status_value = s_rx_byte;
        end else if (rx_enable) begin
            // A status byte leaves the ignore phase, and any status byte but
            // sysex end breaks off a running sysex; both then act as fresh status.
            if ((phase_reg == PH_IGNORE) && is_status) begin
                eff_phase = PH_STATUS;
            end else if ((phase_reg == PH_SYSEX) && is_status &&
                         (s_rx_byte != BYTE_SYSEX_END)) begin
                entry.abort = 1'b1;
                eff_phase   = PH_STATUS;
                phase_next  = PH_STATUS;
            end

            unique case (eff_phase)
                PH_IGNORE: begin
                    phase_next = PH_IGNORE;
                end
                PH_SYSEX: begin
                    if (!is_status) begin
                        entry.main_vld        = 1'b1;
                        entry.main.event_kind = EV_SYSEX_DATA;
                        entry.main.first_data = s_rx_byte;
                    end else begin
                        entry.main_vld        = 1'b1;
                        entry.main.event_kind = EV_SYSEX_END;
                        phase_next            = PH_STATUS;
                    end
                end
                PH_STATUS: begin
                    if (s_rx_byte == BYTE_SYSEX_START) begin
                        phase_next            = PH_SYSEX;
                        held_status_next      = '0;
                        entry.main_vld        = 1'b1;
                        entry.main.event_kind = EV_SYSEX_START;
                    end else if (is_status || (held_status_reg != '0)) begin
                        if (is_status) begin
                            held_status_next = s_rx_byte;
                        end
                        if (!cls.ok) begin
                            phase_next = PH_IGNORE;
                        end else begin
                            held_type_next = cls.kind;
                            held_one_next  = 1'b0;
                            phase_next     = cls.nxt;
                            // A data byte under running status goes straight on
                            // into the data phase.
                            if (!is_status && (cls.nxt == PH_WAIT2)) begin
                                held_first_next = s_rx_byte;
                                held_one_next   = 1'b1;
                                phase_next      = PH_WAIT1;
                            end else if (!is_status && (cls.nxt == PH_WAIT1)) begin
                                phase_next = PH_STATUS;
                                if (cls.kind < TY_MTC_QF) begin
                                    entry.main_vld          = 1'b1;
                                    entry.main.event_kind   = EV_MESSAGE;
                                    entry.main.message_type = cls.kind[2:0];
                                    entry.main.status_value = held_status_reg;
                                    entry.main.first_data   = s_rx_byte;
                                    entry.main.data_count   = DC_ONE;
                                end
                            end
                        end
                    end
                end
                PH_WAIT2: begin
                    held_first_next = s_rx_byte;
                    held_one_next   = 1'b1;
                    phase_next      = PH_WAIT1;
                end
                PH_WAIT1: begin
                    phase_next    = PH_STATUS;
                    held_one_next = 1'b0;
                    if (held_one_reg) begin
                        if ((held_type_reg == TY_NOTE_ON) && (s_rx_byte == 8'h00)) begin
                            pair_type = TY_NOTE_OFF;
                        end
                        if ((pair_type < TY_MTC_QF) || (pair_type == TY_SONG_POS)) begin
                            entry.main_vld          = 1'b1;
                            entry.main.event_kind   = EV_MESSAGE;
                            entry.main.message_type = (pair_type == TY_SONG_POS) ?
                                                      MSG_SONG_POS : pair_type[2:0];
                            entry.main.status_value = held_status_reg;
                            entry.main.first_data   = held_first_reg;
                            entry.main.second_data  = s_rx_byte;
                            entry.main.data_count   = DC_TWO;
                        end
                    end else if (held_type_reg < TY_MTC_QF) begin
                        entry.main_vld          = 1'b1;
                        entry.main.event_kind   = EV_MESSAGE;
                        entry.main.message_type = held_type_reg[2:0];
                        entry.main.status_value = held_status_reg;
                        entry.main.first_data   = s_rx_byte;
                        entry.main.data_count   = DC_ONE;
                    end
                end
                default: begin
                    phase_next = PH_IGNORE;
                end
            endcase
        end
    end

endmodule

/* src/mbsp_queue.sv */
module mbsp_queue
    import mbsp_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     push,
    input  q_entry_t push_entry,
    input  logic     pop,
    output q_entry_t head,
    output logic     empty,
    output logic     full
);

    q_entry_t            store [Q_DEPTH];
    logic [Q_AW-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [Q_AW-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [Q_CW-1:0]     count_reg, count_next;

    assign empty = (count_reg == '0);
    assign full  = (count_reg == Q_CW'(Q_DEPTH));
    assign head  = store[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + Q_AW'(1) : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + Q_AW'(1) : rd_ptr_reg;
        count_next  = count_reg + Q_CW'(push) - Q_CW'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            store[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

/* src/mbsp_back.sv */
module mbsp_back
    import mbsp_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  q_entry_t   head,
    input  logic       empty,
    output logic       pop,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [2:0] m_event_kind,
    output logic [2:0] m_message_type,
    output logic [7:0] m_status_value,
    output logic [7:0] m_first_data,
    output logic [7:0] m_second_data,
    output logic [1:0] m_data_count,
    output logic       m_last_of_run
);

    logic       m_valid_reg, m_valid_next;
    logic       abort_done_reg, abort_done_next;
    ev_fields_t out_reg, out_next;
    logic       last_reg, last_next;
    logic       load;

    assign load = (!m_valid_reg || m_ready) && !empty;

    always_comb begin
        pop             = 1'b0;
        abort_done_next = abort_done_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        out_next        = out_reg;
        last_next       = last_reg;
        if (load) begin
            m_valid_next = 1'b1;
            if (head.abort && !abort_done_reg) begin
                out_next            = '0;
                out_next.event_kind = EV_SYSEX_ABORT;
                last_next           = !head.main_vld;
                if (head.main_vld) begin
                    abort_done_next = 1'b1;
                end else begin
                    pop = 1'b1;
                end
            end else begin
                out_next        = head.main;
                last_next       = 1'b1;
                pop             = 1'b1;
                abort_done_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg    <= 1'b0;
            abort_done_reg <= 1'b0;
        end else begin
            m_valid_reg    <= m_valid_next;
            abort_done_reg <= abort_done_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_reg  <= out_next;
        last_reg <= last_next;
    end

    assign m_valid        = m_valid_reg;
    assign m_event_kind   = out_reg.event_kind;
    assign m_message_type = out_reg.message_type;
    assign m_status_value = out_reg.status_value;
    assign m_first_data   = out_reg.first_data;
    assign m_second_data  = out_reg.second_data;
    assign m_data_count   = out_reg.data_count;
    assign m_last_of_run  = last_reg;

endmodule

/* src/midi_byte_stream_parser.sv */
// The first result of an accepted byte passes through the event queue and then the registered output stage.
// Throughput: one byte per cycle while the event queue has room; a byte whose results are a
// sysex abort and a following event yields two output beats, absorbed by the four-entry event queue.
// Bytes that cause no result occupy no queue entry and no output beat.
// Reset (aresetn low at a clock edge, synchronous) empties the queue and output stage,
// sets reception on, and leaves the parser ignoring bytes until a status byte.
module midi_byte_stream_parser
    import mbsp_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_wr_en,
    input  logic       cfg_wr_data,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_rx_byte,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [2:0] m_event_kind,
    output logic [2:0] m_message_type,
    output logic [7:0] m_status_value,
    output logic [7:0] m_first_data,
    output logic [7:0] m_second_data,
    output logic [1:0] m_data_count,
    output logic       m_last_of_run
);

    // The receive enable register. When it is low, only realtime bytes get
    // through; every other byte is accepted and dropped without touching the
    // parser state.
    logic rx_enable_reg, rx_enable_next;

    // Signals between the parser front end, the event queue and the emitter.
    logic     push;
    q_entry_t push_entry;
    q_entry_t head;
    logic     q_empty;
    logic     q_full;
    logic     pop;

    assign rx_enable_next = cfg_wr_en ? cfg_wr_data : rx_enable_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rx_enable_reg <= 1'b1;
        end else begin
            rx_enable_reg <= rx_enable_next;
        end
    end

    // The front end takes one beat per cycle whenever the queue has room. It
    // keeps running status, assembles messages and condenses everything one
    // byte causes into a single queue entry.
    mbsp_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_rx_byte (s_rx_byte),
        .rx_enable (rx_enable_reg),
        .q_full    (q_full),
        .push      (push),
        .entry     (push_entry)
    );

    // The queue decouples the front end from a stalled result channel.
    mbsp_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head       (head),
        .empty      (q_empty),
        .full       (q_full)
    );

    // The emitter expands each entry into one or two result beats, through a
    // registered output stage, and marks the last beat of each byte.
    mbsp_back u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .head           (head),
        .empty          (q_empty),
        .pop            (pop),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_event_kind   (m_event_kind),
        .m_message_type (m_message_type),
        .m_status_value (m_status_value),
        .m_first_data   (m_first_data),
        .m_second_data  (m_second_data),
        .m_data_count   (m_data_count),
        .m_last_of_run  (m_last_of_run)
    );

    // The front end never writes into a full queue.
    a_no_push_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> !q_full)
        else $error("event queue written while full");

    // A non-realtime byte taken while reception is off produces nothing.
    a_disabled_drops: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && !rx_enable_reg && (s_rx_byte < BYTE_REALTIME)) |-> !push)
        else $error("result queued while reception disabled");

    // The second beat of a two-beat run follows at once from the same entry.
    a_run_continues: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && !m_last_of_run) |=> m_valid)
        else $error("run of results broken off");

    // A message beat always carries one or two data bytes.
    a_msg_has_data: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_event_kind == EV_MESSAGE)) |->
        ((m_data_count == DC_ONE) || (m_data_count == DC_TWO)))
        else $error("message beat without data");

endmodule
